// ===== design/vsc_pkg.sv =====
`timescale 1ns / 1ps
package vsc_pkg;

  // Field widths fixed by the item format
  localparam int KEY_IDX_W = 6;
  localparam int KEY_VAL_W = 32;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Alphabet: symbols 32..255, 224 of them (224 = 7 * 32)
  localparam int SYM_LOW   = 32;
  localparam int SYM_COUNT = 224;
  localparam int LOW_BITS  = 5;
  localparam int HI_MOD    = 7;

  // Register codes, taken from paddr[2]
  localparam logic REG_ENCRYPT = 1'b0;
  localparam logic REG_KEY_LEN = 1'b1;

  // Action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_CIPHER = 1'b1;

  typedef struct packed {
    logic             encrypt;
    logic [LEN_W-1:0] key_length;
  } vsc_cfg_t;

endpackage

// ===== design/vsc_cfg_regs.sv =====
`timescale 1ns / 1ps
module vsc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vsc_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [vsc_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [vsc_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output vsc_pkg::vsc_cfg_t            cfg
);

  logic                     encrypt_r;
  logic [vsc_pkg::LEN_W-1:0] key_length_r;
  logic                     wr_en;
  logic                     reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encrypt_r    <= 1'b1;
      key_length_r <= vsc_pkg::LEN_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        vsc_pkg::REG_ENCRYPT: encrypt_r    <= cfg_pwdata[0];
        vsc_pkg::REG_KEY_LEN: key_length_r <= cfg_pwdata[vsc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      vsc_pkg::REG_ENCRYPT: cfg_prdata = vsc_pkg::APB_DW'(encrypt_r);
      vsc_pkg::REG_KEY_LEN: cfg_prdata = vsc_pkg::APB_DW'(key_length_r);
      default:              cfg_prdata = '0;
    endcase
  end

  assign cfg.encrypt    = encrypt_r;
  assign cfg.key_length = key_length_r;

endmodule

// ===== design/vsc_key_mem.sv =====
`timescale 1ns / 1ps
module vsc_key_mem #(
  parameter int KEY_DEPTH = 64,
  parameter int AW        = 6
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [vsc_pkg::KEY_IDX_W-1:0]    wr_index,
  input  logic [vsc_pkg::KEY_VAL_W-1:0]    wr_value,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic [vsc_pkg::BYTE_W-1:0]       rd_data
);

  localparam int EXT_W = (AW > vsc_pkg::KEY_IDX_W) ? AW : vsc_pkg::KEY_IDX_W;

  logic [vsc_pkg::BYTE_W-1:0] mem [KEY_DEPTH];
  logic [vsc_pkg::BYTE_W-1:0] rd_data_r;
  logic [EXT_W-1:0]           wr_ext;
  logic                       wr_ok;
  logic [vsc_pkg::BYTE_W-1:0] wr_shift;

  // Floored remainder of a signed 32-bit value by 224.
  // Low five bits pass; the upper 27 bits reduce mod 7 by summing octal
  // digits (8 = 1 mod 7). 2^32 mod 224 is 32, so a negative value takes
  // one off the upper residue.
  function automatic logic [vsc_pkg::BYTE_W-1:0] reduce_shift(
    input logic [vsc_pkg::KEY_VAL_W-1:0] raw
  );
    logic [5:0] dsum;
    logic [3:0] f1;
    logic [3:0] f2;
    logic [2:0] h;
    dsum = '0;
    for (int i = 0; i < 9; i++) begin
      dsum = dsum + 6'(raw[vsc_pkg::LOW_BITS + 3*i +: 3]);
    end
    f1 = 4'(dsum[2:0]) + 4'(dsum[5:3]);
    f2 = 4'(f1[2:0]) + 4'(f1[3]);
    h  = (f2 >= 4'(vsc_pkg::HI_MOD)) ? 3'(f2 - 4'(vsc_pkg::HI_MOD)) : f2[2:0];
    if (raw[vsc_pkg::KEY_VAL_W-1]) begin
      h = (h == 3'd0) ? 3'(vsc_pkg::HI_MOD - 1) : h - 3'd1;
    end
    return {h, raw[vsc_pkg::LOW_BITS-1:0]};
  endfunction

  assign wr_ext   = EXT_W'(wr_index);
  assign wr_ok    = wr_en && (int'(wr_index) < KEY_DEPTH);
  assign wr_shift = reduce_shift(wr_value);

  // Write reduced shift; drop loads beyond the store
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ext[AW-1:0]] <= wr_shift;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/vsc_pos_seq.sv =====
`timescale 1ns / 1ps
module vsc_pos_seq #(
  parameter int KEY_DEPTH = 64,
  parameter int AW        = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vsc_pkg::vsc_cfg_t cfg,
  input  logic              step,
  input  logic              last,
  output logic [AW-1:0]     rd_addr,
  output logic              len_zero
);

  localparam int EXT_W = (AW > vsc_pkg::LEN_W) ? AW : vsc_pkg::LEN_W;

  logic [vsc_pkg::LEN_W-1:0] pos_r;
  logic [vsc_pkg::LEN_W-1:0] pos_nxt;
  logic [vsc_pkg::LEN_W-1:0] len;
  logic [vsc_pkg::LEN_W-1:0] cur;
  logic [vsc_pkg::LEN_W-1:0] inc;
  logic [EXT_W-1:0]          cur_ext;

  // Clamp length to the store depth
  always_comb begin
    if (int'(cfg.key_length) > KEY_DEPTH) begin
      len = vsc_pkg::LEN_W'(KEY_DEPTH);
    end else begin
      len = cfg.key_length;
    end
  end

  assign len_zero = (len == '0);
  assign cur      = (pos_r >= len) ? '0 : pos_r;
  assign inc      = cur + vsc_pkg::LEN_W'(1);
  assign cur_ext  = EXT_W'(cur);
  assign rd_addr  = cur_ext[AW-1:0];

  // Advance and wrap the position; return to zero after a last byte
  always_comb begin
    pos_nxt = pos_r;
    if (step) begin
      if (len_zero || last || inc >= len) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== design/vsc_shift_stage.sv =====
`timescale 1ns / 1ps
module vsc_shift_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [vsc_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        last_in,
  input  logic                        len_zero,
  input  logic                        encrypt,
  input  logic [vsc_pkg::BYTE_W-1:0]  shift,
  input  logic                        out_stall,
  output logic                        ready,
  output logic                        out_valid,
  output logic [vsc_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);

  logic                       s1_valid_r;
  logic [vsc_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_last_r;
  logic                       s1_pass_r;
  logic                       out_valid_r;
  logic [vsc_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_last_r;
  logic                       s1_adv;
  logic [vsc_pkg::BYTE_W:0]   sum9;
  logic [vsc_pkg::BYTE_W:0]   diff9;
  logic [vsc_pkg::BYTE_W-1:0] result;

  assign s1_adv = !out_valid_r || !out_stall;
  assign ready  = !s1_valid_r || s1_adv;

  // Hold the byte while its key shift is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte_r <= byte_in;
      s1_last_r <= last_in;
      s1_pass_r <= len_zero || (byte_in < vsc_pkg::BYTE_W'(vsc_pkg::SYM_LOW));
    end
  end

  // Shift within the alphabet, wrapping by 224; pass-through bytes keep their value
  always_comb begin
    sum9  = {1'b0, s1_byte_r} + {1'b0, shift};
    diff9 = {1'b0, s1_byte_r} - {1'b0, shift};
    if (s1_pass_r) begin
      result = s1_byte_r;
    end else if (encrypt) begin
      result = sum9[vsc_pkg::BYTE_W] ?
               vsc_pkg::BYTE_W'(sum9 - (vsc_pkg::BYTE_W+1)'(vsc_pkg::SYM_COUNT)) :
               sum9[vsc_pkg::BYTE_W-1:0];
    end else if (diff9[vsc_pkg::BYTE_W] ||
                 diff9[vsc_pkg::BYTE_W-1:0] < vsc_pkg::BYTE_W'(vsc_pkg::SYM_LOW)) begin
      result = vsc_pkg::BYTE_W'(diff9 + (vsc_pkg::BYTE_W+1)'(vsc_pkg::SYM_COUNT));
    end else begin
      result = diff9[vsc_pkg::BYTE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_byte_r <= result;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/vigenere_shift_cipher_224.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; the key store has one read and one write port.
// A byte item is registered together with its key store read, then moves into the
//   output register, where an output stall holds it. Load items produce
//   no result.
// Reset (rst_n low, synchronous): key position to 0, encrypt_mode to 1,
//   key_length to 1, pipeline emptied. Key store contents are not cleared.
module vigenere_shift_cipher_224 #(
  parameter int KEY_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_action,
  input  logic [vsc_pkg::KEY_IDX_W-1:0]      in_key_index,
  input  logic signed [vsc_pkg::KEY_VAL_W-1:0] in_key_value,
  input  logic [vsc_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vsc_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [vsc_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [vsc_pkg::APB_DW-1:0]         cfg_pwdata,
  output logic [vsc_pkg::APB_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  vsc_pkg::vsc_cfg_t          cfg;
  logic                       ready;
  logic                       accept;
  logic                       byte_acc;
  logic                       load_acc;
  logic [AW-1:0]              rd_addr;
  logic                       len_zero;
  logic [vsc_pkg::BYTE_W-1:0] shift;

  // Split accepted items into key loads and byte items
  assign in_stall = !ready;
  assign accept   = in_valid && ready;
  assign byte_acc = accept && (in_action == vsc_pkg::ACT_CIPHER);
  assign load_acc = accept && (in_action == vsc_pkg::ACT_LOAD);

  vsc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  vsc_pos_seq #(
    .KEY_DEPTH (KEY_DEPTH),
    .AW        (AW)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (byte_acc),
    .last     (in_last_byte),
    .rd_addr  (rd_addr),
    .len_zero (len_zero)
  );

  vsc_key_mem #(
    .KEY_DEPTH (KEY_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (load_acc),
    .wr_index (in_key_index),
    .wr_value (in_key_value),
    .rd_en    (byte_acc),
    .rd_addr  (rd_addr),
    .rd_data  (shift)
  );

  vsc_shift_stage u_shift (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (byte_acc),
    .byte_in   (in_byte),
    .last_in   (in_last_byte),
    .len_zero  (len_zero),
    .encrypt   (cfg.encrypt),
    .shift     (shift),
    .out_stall (out_stall),
    .ready     (ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 80;
  localparam int KEY_SLOTS    = 64;
  localparam int PHASE_ITEMS  = 170;

  typedef struct {
    logic                                 action;
    logic [vsc_pkg::KEY_IDX_W-1:0]        key_index;
    logic signed [vsc_pkg::KEY_VAL_W-1:0] key_value;
    logic [vsc_pkg::BYTE_W-1:0]           data;
    logic                                 last;
  } stream_item_t;

  typedef struct {
    logic [vsc_pkg::BYTE_W-1:0] data;
    logic                       last;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 in_action = 1'b0;
  logic [vsc_pkg::KEY_IDX_W-1:0]        in_key_index = '0;
  logic signed [vsc_pkg::KEY_VAL_W-1:0] in_key_value = '0;
  logic [vsc_pkg::BYTE_W-1:0]           in_byte = '0;
  logic                                 in_last_byte = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [vsc_pkg::BYTE_W-1:0]           out_byte;
  logic                                 out_last;
  logic                                 cfg_psel = 1'b0;
  logic                                 cfg_penable = 1'b0;
  logic                                 cfg_pwrite = 1'b0;
  logic [vsc_pkg::APB_AW-1:0]           cfg_paddr = '0;
  logic [vsc_pkg::APB_DW-1:0]           cfg_pwdata = '0;
  logic [vsc_pkg::APB_DW-1:0]           cfg_prdata;
  logic                                 cfg_pready;

  // Cipher state mirrored by the predictor
  logic [7:0] shift_table [KEY_SLOTS];
  int         key_pos = 0;
  logic       mode_encrypt = 1'b1;
  logic [vsc_pkg::LEN_W-1:0] key_len = 7'd1;

  stream_item_t queued_items [$];
  cipher_out_t  expected_bytes [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int bytes_checked = 0;
  int loads_sent = 0;
  int cfg_writes = 0;

  vigenere_shift_cipher_224 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_key_index (in_key_index),
    .in_key_value (in_key_value),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Reduce a signed key to 0..223 with a floored remainder
  function automatic logic [7:0] reduce_key(logic signed [vsc_pkg::KEY_VAL_W-1:0] raw);
    int v;
    int r;
    v = raw;
    r = v % vsc_pkg::SYM_COUNT;
    if (r < 0) r += vsc_pkg::SYM_COUNT;
    return r[7:0];
  endfunction

  // Apply one accepted item to the mirrored state; queue the byte it yields
  task automatic predict_cipher(stream_item_t it);
    int len;
    int idx;
    int s;
    int n;
    cipher_out_t res;
    if (it.action == vsc_pkg::ACT_LOAD) begin
      shift_table[it.key_index] = reduce_key(it.key_value);
      loads_sent++;
      return;
    end
    len = (key_len > KEY_SLOTS) ? KEY_SLOTS : key_len;
    res.data = it.data;
    res.last = it.last;
    if (len == 0) begin
      key_pos = 0;
    end else begin
      if (key_pos >= len) key_pos = 0;
      if (it.data >= vsc_pkg::SYM_LOW) begin
        idx = it.data - vsc_pkg::SYM_LOW;
        s = shift_table[key_pos];
        if (mode_encrypt) n = (idx + s) % vsc_pkg::SYM_COUNT;
        else n = (idx + vsc_pkg::SYM_COUNT - s) % vsc_pkg::SYM_COUNT;
        res.data = 8'(n + vsc_pkg::SYM_LOW);
      end
      key_pos++;
      if (key_pos >= len) key_pos = 0;
    end
    if (it.last) key_pos = 0;
    expected_bytes.push_back(res);
  endtask

  // Driver: present queued items, hold while stalled, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cipher(queued_items[0]);
        void'(queued_items.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_action    <= queued_items[0].action;
          in_key_index <= queued_items[0].key_index;
          in_key_value <= queued_items[0].key_value;
          in_byte      <= queued_items[0].data;
          in_last_byte <= queued_items[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expected byte, drive stall
  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0d, out_last %0d", out_byte, out_last);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0d, got %0d", want.data, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("vigenere_shift_cipher_224 test failed");
      $finish;
    end
  end

  task automatic cfg_write(logic reg_code, logic [vsc_pkg::APB_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_code, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_code == vsc_pkg::REG_ENCRYPT) mode_encrypt = value[0];
    else key_len = value[vsc_pkg::LEN_W-1:0];
    cfg_writes++;
  endtask

  // Wait until nothing is queued or in flight, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_items.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_idle_pct  <= 77;
        recv_stall_pct <= 0;
      end
      2: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 77;
      end
      default: begin
        send_idle_pct  <= 26;
        recv_stall_pct <= 26;
      end
    endcase
  endtask

  function automatic logic signed [vsc_pkg::KEY_VAL_W-1:0] rand_key_value();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return 32'(int'($urandom_range(500)) - 250);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(int slot, logic signed [vsc_pkg::KEY_VAL_W-1:0] value);
    stream_item_t it;
    it.action    = vsc_pkg::ACT_LOAD;
    it.key_index = slot[vsc_pkg::KEY_IDX_W-1:0];
    it.key_value = value;
    it.data      = vsc_pkg::BYTE_W'($urandom);
    it.last      = 1'($urandom_range(1));
    queued_items.push_back(it);
  endtask

  task automatic push_byte(logic [vsc_pkg::BYTE_W-1:0] data, logic last);
    stream_item_t it;
    it.action    = vsc_pkg::ACT_CIPHER;
    it.key_index = vsc_pkg::KEY_IDX_W'($urandom);
    it.key_value = $urandom;
    it.data      = data;
    it.last      = last;
    queued_items.push_back(it);
  endtask

  // Mostly well-formed messages, some control bytes, some missing the end mark,
  // with key reloads mixed in
  task automatic run_random_phase(int mode, int klen, bit long_hold, bit pause);
    int count;
    int msg_len;
    bit drop_last;
    bit paused;
    logic [vsc_pkg::BYTE_W-1:0] data;
    count = 0;
    paused = 1'b0;
    set_idling(mode);
    cfg_write(vsc_pkg::REG_ENCRYPT, $urandom_range(1));
    cfg_write(vsc_pkg::REG_KEY_LEN, klen);
    if (long_hold) hold_requests <= hold_requests + 1;
    while (count < PHASE_ITEMS) begin
      if ($urandom_range(99) < 10) begin
        push_load($urandom_range(KEY_SLOTS - 1), rand_key_value());
        count++;
      end else begin
        msg_len = $urandom_range(24, 1);
        drop_last = ($urandom_range(99) < 10);
        for (int k = 0; k < msg_len; k++) begin
          if ($urandom_range(99) < 15) begin
            data = vsc_pkg::BYTE_W'($urandom_range(vsc_pkg::SYM_LOW - 1));
          end else begin
            data = vsc_pkg::BYTE_W'($urandom_range(255, vsc_pkg::SYM_LOW));
          end
          push_byte(data, (k == msg_len - 1) && !drop_last);
          count++;
        end
      end
      // hold the sender until everything sent so far has come back
      if (pause && !paused && count >= PHASE_ITEMS / 2) begin
        paused = 1'b1;
        wait_idle();
      end
    end
    wait_idle();
  endtask

  initial begin
    int klen;
    for (int i = 0; i < KEY_SLOTS; i++) shift_table[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the key store first so that no unwritten entry is ever read
    push_load(0, 32'sd0);
    push_load(1, -32'sd1);
    push_load(2, 32'sh7FFF_FFFF);
    push_load(3, 32'sh8000_0000);
    push_load(4, 32'sd223);
    push_load(5, 32'sd224);
    push_load(6, -32'sd224);
    push_load(7, -32'sd225);
    for (int i = 8; i < KEY_SLOTS; i++) push_load(i, rand_key_value());
    wait_idle();

    // Field extremes and the control-byte boundary, encrypting
    cfg_write(vsc_pkg::REG_ENCRYPT, 1);
    cfg_write(vsc_pkg::REG_KEY_LEN, 4);
    push_byte(8'd0, 1'b0);
    push_byte(8'd31, 1'b0);
    push_byte(8'd32, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd200, 1'b1);
    // Leave the position mid-key, then shrink the key below it
    for (int i = 0; i < 7; i++) push_byte(8'(65 + i), 1'b0);
    wait_idle();
    cfg_write(vsc_pkg::REG_KEY_LEN, 3);
    push_byte(8'd100, 1'b0);
    push_byte(8'd101, 1'b1);
    wait_idle();
    // Decrypt with the full key
    cfg_write(vsc_pkg::REG_ENCRYPT, 0);
    cfg_write(vsc_pkg::REG_KEY_LEN, 64);
    push_byte(8'd32, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd33, 1'b0);
    push_byte(8'd31, 1'b1);
    wait_idle();
    // Zero length passes bytes through; oversize length saturates
    cfg_write(vsc_pkg::REG_KEY_LEN, 0);
    push_byte(8'd40, 1'b0);
    push_byte(8'd255, 1'b0);
    wait_idle();
    cfg_write(vsc_pkg::REG_KEY_LEN, 127);
    push_byte(8'd50, 1'b0);
    push_byte(8'd250, 1'b1);
    wait_idle();

    // Random phases over all idling modes and a spread of key lengths
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: klen = 64;
        1: klen = 1;
        3: klen = 0;
        4: klen = 127;
        5: klen = 65;
        default: klen = $urandom_range(63, 2);
      endcase
      run_random_phase(p % 4, klen, (p == 0 || p == 6), (p == 1 || p == 5));
    end

    wait_idle();
    $display("checked %0d ciphered bytes, %0d key loads, %0d register writes",
             bytes_checked, loads_sent, cfg_writes);
    $display("both directions, key lengths 0..127, control bytes and long output stalls");
    if (fail_count == 0) begin
      $display("vigenere_shift_cipher_224 test passed");
    end else begin
      $display("vigenere_shift_cipher_224 test failed");
    end
    $finish;
  end

endmodule
